/* src/assert_macros.svh */
// Assertion macros shared by the radial gradient disc RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked every cycle outside reset.
`define RGD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked outside reset.
`define RGD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checked also during reset.
`define RGD_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* src/rgd_pkg.sv */
// Shared types and constants of the radial gradient disc block.
// No dependencies.
package rgd_pkg;

  localparam int unsigned MAX_DIM_DEF = 1024;
  localparam int unsigned DIM_REG_W   = 11;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned N_CH        = 3;

  localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 11'd32;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 11'd32;
  localparam logic [COLOR_W-1:0]   PEAK_RST   = 8'd255;
  localparam logic [COLOR_W-1:0]   ALPHA_ON   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RED    = 3'd2,
    REG_GREEN  = 3'd3,
    REG_BLUE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] alpha;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_rsp_t;

endpackage

/* src/radial_gradient_disc_pixel_top.sv */
// Top level of the radial gradient disc pixel generator.
// Depends on rgd_pkg, rgd_sqrt_cell, rgd_div_cell and assert_macros.svh.
`include "assert_macros.svh"

// Returns one RGBA pixel of a disc centred in an image_width x image_height
// sprite for each requested coordinate. One request is taken every clock
// cycle while the chain is not halted. Each request passes stages A, B
// and C, then one square root cell per root bit, then one divide cell per
// color bit. The whole chain moves together and halts only while a finished
// response is held back by out_stall. Configuration is taken directly and
// must only change while no request is in flight.
module radial_gradient_disc_pixel_top #(
  parameter int unsigned MAX_DIM = rgd_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgd_pkg::DIM_REG_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rgd_pkg::pixel_req_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rgd_pkg::pixel_rsp_t                 out_data
);

  localparam int unsigned CW     = $clog2(MAX_DIM + 1);  // clamped dimension
  localparam int unsigned SW     = CW + 1;               // signed half-pixel offset
  localparam int unsigned S_W    = 2 * CW + 1;           // squared radius
  localparam int unsigned PP_W   = 2 * rgd_pkg::COLOR_W;
  localparam int unsigned RW     = rgd_pkg::COLOR_W + CW; // root width
  localparam int unsigned NW     = 2 * RW;
  localparam int unsigned SIDE_W = CW + 1;
  localparam int unsigned QW     = rgd_pkg::COLOR_W;
  localparam int unsigned NCH    = rgd_pkg::N_CH;

  // Configuration registers
  logic [rgd_pkg::DIM_REG_W-1:0] image_width, image_height;
  logic [NCH-1:0][QW-1:0]        peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rgd_pkg::WIDTH_RST;
      image_height <= rgd_pkg::HEIGHT_RST;
      peak         <= {NCH{rgd_pkg::PEAK_RST}};
    end else if (cfg_we) begin
      case (rgd_pkg::cfg_reg_t'(cfg_index))
        rgd_pkg::REG_WIDTH:  image_width  <= cfg_data;
        rgd_pkg::REG_HEIGHT: image_height <= cfg_data;
        rgd_pkg::REG_RED:    peak[0]      <= cfg_data[QW-1:0];
        rgd_pkg::REG_GREEN:  peak[1]      <= cfg_data[QW-1:0];
        rgd_pkg::REG_BLUE:   peak[2]      <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  // Whole chain advances unless the output holds a stalled response.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage A: clamp, bounds check, doubled offsets
  logic [CW-1:0] w_c, h_c, m_c;
  logic          inb_c;
  logic signed [SW-1:0] dx_c, dy_c;

  always_comb begin
    if (32'(image_width) > MAX_DIM) w_c = CW'(MAX_DIM);
    else                            w_c = CW'(image_width);
    if (32'(image_height) > MAX_DIM) h_c = CW'(MAX_DIM);
    else                             h_c = CW'(image_height);
    m_c   = (w_c < h_c) ? w_c : h_c;
    inb_c = (m_c != '0) && (32'(in_data.pixel_x) < 32'(w_c))
            && (32'(in_data.pixel_y) < 32'(h_c));
    dx_c  = SW'(2 * int'(in_data.pixel_x) - int'(w_c));
    dy_c  = SW'(2 * int'(in_data.pixel_y) - int'(h_c));
  end

  logic                 a_valid, a_inb;
  logic [CW-1:0]        a_m;
  logic signed [SW-1:0] a_dx, a_dy;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_inb <= inb_c;
      a_m   <= m_c;
      a_dx  <= dx_c;
      a_dy  <= dy_c;
    end
  end

  // Stage B: squared radius, inside test, peak squared
  logic signed [2*SW-1:0] dx_w, dy_w;  // offsets widened for full squares
  logic [S_W-1:0] s_c;
  logic [S_W-1:0] mm_c;
  logic           in_c;

  always_comb begin
    dx_w = (2*SW)'(a_dx);
    dy_w = (2*SW)'(a_dy);
    s_c  = S_W'($unsigned(dx_w * dx_w)) + S_W'($unsigned(dy_w * dy_w));
    mm_c = S_W'(a_m) * S_W'(a_m);
    in_c = a_inb && (s_c <= mm_c);
  end

  logic                     b_valid, b_in;
  logic [CW-1:0]            b_m;
  logic [S_W-1:0]           b_s;
  logic [NCH-1:0][PP_W-1:0] b_pp;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_in <= in_c;
      b_m  <= a_m;
      b_s  <= in_c ? s_c : '0;  // outside pixels run through as zero
      for (int c = 0; c < NCH; c++) b_pp[c] <= PP_W'(peak[c]) * PP_W'(peak[c]);
    end
  end

  // Stage C: radicand peak^2 * S per channel
  logic                   c_valid;
  logic [SIDE_W-1:0]      c_side;
  logic [NCH-1:0][NW-1:0] c_n;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= {b_in, b_m};
      for (int c = 0; c < NCH; c++) c_n[c] <= NW'(b_pp[c]) * NW'(b_s);
    end
  end

  // Square root chain: one cell per root bit
  logic [RW:0]                          sq_valid;
  logic [RW:0][NCH-1:0][NW-1:0]         sq_n;
  logic [RW:0][NCH-1:0][RW+1:0]         sq_rem;
  logic [RW:0][NCH-1:0][RW-1:0]         sq_root;
  logic [RW:0][SIDE_W-1:0]              sq_side;

  assign sq_valid[0] = c_valid;
  assign sq_n[0]     = c_n;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = c_side;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rgd_sqrt_cell #(.RW(RW), .SIDE_W(SIDE_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .valid_prev (sq_valid[i]),
      .n_prev     (sq_n[i]),
      .rem_prev   (sq_rem[i]),
      .root_prev  (sq_root[i]),
      .side_prev  (sq_side[i]),
      .valid      (sq_valid[i+1]),
      .n          (sq_n[i+1]),
      .rem        (sq_rem[i+1]),
      .root       (sq_root[i+1]),
      .side       (sq_side[i+1])
    );
  end

  // Divide chain: root < 256*m, so the top CW root bits seed the remainder
  logic [QW:0]                    dv_valid, dv_in;
  logic [QW:0][CW-1:0]            dv_m;
  logic [QW:0][NCH-1:0][CW-1:0]   dv_rem;
  logic [QW:0][NCH-1:0][QW-1:0]   dv_bits, dv_q;

  assign dv_valid[0] = sq_valid[RW];
  assign dv_in[0]    = sq_side[RW][CW];
  assign dv_m[0]     = sq_side[RW][CW-1:0];
  assign dv_q[0]     = '0;

  for (genvar c = 0; c < NCH; c++) begin : g_seed
    assign dv_rem[0][c]  = sq_root[RW][c][RW-1:QW];
    assign dv_bits[0][c] = sq_root[RW][c][QW-1:0];
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    rgd_div_cell #(.CW(CW)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .en           (en),
      .valid_prev   (dv_valid[i]),
      .in_disc_prev (dv_in[i]),
      .m_prev       (dv_m[i]),
      .rem_prev     (dv_rem[i]),
      .bits_prev    (dv_bits[i]),
      .q_prev       (dv_q[i]),
      .valid        (dv_valid[i+1]),
      .in_disc      (dv_in[i+1]),
      .m            (dv_m[i+1]),
      .rem          (dv_rem[i+1]),
      .bits         (dv_bits[i+1]),
      .q            (dv_q[i+1])
    );
  end

  // Last divide cell is the output register. Outside pixels are forced to
  // black, since a zero diameter would otherwise divide to all ones.
  assign out_valid      = dv_valid[QW];
  assign out_data.alpha = dv_in[QW] ? rgd_pkg::ALPHA_ON : '0;
  assign out_data.red   = dv_in[QW] ? dv_q[QW][0] : '0;
  assign out_data.green = dv_in[QW] ? dv_q[QW][1] : '0;
  assign out_data.blue  = dv_in[QW] ? dv_q[QW][2] : '0;

  `RGD_ASSERT(a_alpha_code, !out_valid || out_data.alpha == '0 || out_data.alpha == rgd_pkg::ALPHA_ON, "alpha not 0 or 255")
  `RGD_ASSERT_IMP(a_outside_black, out_valid && out_data.alpha == '0, out_data.red == '0 && out_data.green == '0 && out_data.blue == '0, "outside pixel has color")
  `RGD_ASSERT_IMP(a_peak_bound, out_valid, out_data.red <= peak[0] && out_data.green <= peak[1] && out_data.blue <= peak[2], "channel above peak")
  `RGD_ASSERT_RST(a_reset_empty, $past(rst) && !rst, !out_valid, "response right after reset")

endmodule

/* src/rgd_sqrt_cell.sv */
// One digit step of the bit-serial square root chain, three color lanes.
// Depends on rgd_pkg.
module rgd_sqrt_cell #(
  parameter int unsigned RW     = 19,
  parameter int unsigned SIDE_W = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_prev,
  input  logic [rgd_pkg::N_CH-1:0][2*RW-1:0] n_prev,
  input  logic [rgd_pkg::N_CH-1:0][RW+1:0]   rem_prev,
  input  logic [rgd_pkg::N_CH-1:0][RW-1:0]   root_prev,
  input  logic [SIDE_W-1:0]           side_prev,
  output logic                        valid,
  output logic [rgd_pkg::N_CH-1:0][2*RW-1:0] n,
  output logic [rgd_pkg::N_CH-1:0][RW+1:0]   rem,
  output logic [rgd_pkg::N_CH-1:0][RW-1:0]   root,
  output logic [SIDE_W-1:0]           side
);

  logic [rgd_pkg::N_CH-1:0][2*RW-1:0] n_next;
  logic [rgd_pkg::N_CH-1:0][RW+1:0]   rem_next;
  logic [rgd_pkg::N_CH-1:0][RW-1:0]   root_next;

  always_comb begin
    logic [RW+3:0] r2;
    logic [RW+3:0] trial;
    for (int c = 0; c < rgd_pkg::N_CH; c++) begin
      r2    = {rem_prev[c], n_prev[c][2*RW-1:2*RW-2]};
      trial = {2'b00, root_prev[c], 2'b01};
      n_next[c] = {n_prev[c][2*RW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_next[c]  = (RW+2)'(r2 - trial);
        root_next[c] = {root_prev[c][RW-2:0], 1'b1};
      end else begin
        rem_next[c]  = (RW+2)'(r2);
        root_next[c] = {root_prev[c][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n    <= n_next;
      rem  <= rem_next;
      root <= root_next;
      side <= side_prev;
    end
  end

endmodule

/* src/rgd_div_cell.sv */
// One quotient bit step of the restoring divide by the disc diameter.
// Depends on rgd_pkg.
module rgd_div_cell #(
  parameter int unsigned CW = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_prev,
  input  logic                        in_disc_prev,
  input  logic [CW-1:0]               m_prev,
  input  logic [rgd_pkg::N_CH-1:0][CW-1:0]              rem_prev,
  input  logic [rgd_pkg::N_CH-1:0][rgd_pkg::COLOR_W-1:0] bits_prev,
  input  logic [rgd_pkg::N_CH-1:0][rgd_pkg::COLOR_W-1:0] q_prev,
  output logic                        valid,
  output logic                        in_disc,
  output logic [CW-1:0]               m,
  output logic [rgd_pkg::N_CH-1:0][CW-1:0]              rem,
  output logic [rgd_pkg::N_CH-1:0][rgd_pkg::COLOR_W-1:0] bits,
  output logic [rgd_pkg::N_CH-1:0][rgd_pkg::COLOR_W-1:0] q
);

  localparam int unsigned QW = rgd_pkg::COLOR_W;

  logic [rgd_pkg::N_CH-1:0][CW-1:0] rem_next;
  logic [rgd_pkg::N_CH-1:0][QW-1:0] bits_next;
  logic [rgd_pkg::N_CH-1:0][QW-1:0] q_next;

  always_comb begin
    logic [CW:0] r2;
    for (int c = 0; c < rgd_pkg::N_CH; c++) begin
      r2 = {rem_prev[c], bits_prev[c][QW-1]};
      bits_next[c] = {bits_prev[c][QW-2:0], 1'b0};
      if (r2 >= {1'b0, m_prev}) begin
        rem_next[c] = CW'(r2 - {1'b0, m_prev});
        q_next[c]   = {q_prev[c][QW-2:0], 1'b1};
      end else begin
        rem_next[c] = CW'(r2);
        q_next[c]   = {q_prev[c][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_disc <= in_disc_prev;
      m       <= m_prev;
      rem     <= rem_next;
      bits    <= bits_next;
      q       <= q_next;
    end
  end

endmodule

/* tb/tb_radial_gradient_disc_pixel_top.sv */
// Self-checking testbench for the radial gradient disc pixel generator.
// Depends on rgd_pkg and radial_gradient_disc_pixel_top.
module tb_radial_gradient_disc_pixel_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM = rgd_pkg::MAX_DIM_DEF;
  // Extra wait after each drain, well beyond the pipeline depth; leave slack.
  localparam int unsigned DRAIN_CYCLES = 64;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [rgd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rgd_pkg::DIM_REG_W-1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  rgd_pkg::pixel_req_t in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rgd_pkg::pixel_rsp_t out_data;

  radial_gradient_disc_pixel_top #(.MAX_DIM(MAX_DIM)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the sprite settings, updated with every register write.
  logic [rgd_pkg::DIM_REG_W-1:0] img_w, img_h;
  logic [rgd_pkg::COLOR_W-1:0]   peak_r, peak_g, peak_b;

  rgd_pkg::pixel_rsp_t expected_pixels[$];
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned pixels_seen = 0;
  int unsigned inside_seen = 0;
  int unsigned settings_used = 0;

  // Bitwise integer square root, rounded down.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [rgd_pkg::COLOR_W-1:0] channel_level(
      logic [rgd_pkg::COLOR_W-1:0] peak, longint unsigned s, longint unsigned m);
    longint unsigned p;
    p = peak;
    return rgd_pkg::COLOR_W'(int_sqrt(p * p * s) / m);
  endfunction

  // Expected disc pixel for one coordinate under current settings.
  function automatic rgd_pkg::pixel_rsp_t disc_pixel(rgd_pkg::pixel_req_t req);
    rgd_pkg::pixel_rsp_t r;
    longint unsigned w, h, m, s;
    longint dx, dy;
    r = '0;
    w = (img_w > MAX_DIM) ? MAX_DIM : img_w;
    h = (img_h > MAX_DIM) ? MAX_DIM : img_h;
    m = (w < h) ? w : h;
    if (m == 0 || req.pixel_x >= w || req.pixel_y >= h) return r;
    dx = 2 * longint'(req.pixel_x) - longint'(w);
    dy = 2 * longint'(req.pixel_y) - longint'(h);
    s = dx * dx + dy * dy;
    if (s <= m * m) begin
      r.alpha = rgd_pkg::ALPHA_ON;
      r.red   = channel_level(peak_r, s, m);
      r.green = channel_level(peak_g, s, m);
      r.blue  = channel_level(peak_b, s, m);
    end
    return r;
  endfunction

  // Drives one write; the caller drops cfg_we after the last one.
  task automatic write_reg(rgd_pkg::cfg_reg_t idx, logic [rgd_pkg::DIM_REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      rgd_pkg::REG_WIDTH:  img_w  = val;
      rgd_pkg::REG_HEIGHT: img_h  = val;
      rgd_pkg::REG_RED:    peak_r = val[rgd_pkg::COLOR_W-1:0];
      rgd_pkg::REG_GREEN:  peak_g = val[rgd_pkg::COLOR_W-1:0];
      rgd_pkg::REG_BLUE:   peak_b = val[rgd_pkg::COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sprite(logic [rgd_pkg::DIM_REG_W-1:0] w,
      logic [rgd_pkg::DIM_REG_W-1:0] h, logic [rgd_pkg::COLOR_W-1:0] r,
      logic [rgd_pkg::COLOR_W-1:0] g, logic [rgd_pkg::COLOR_W-1:0] b);
    write_reg(rgd_pkg::REG_WIDTH, w);
    write_reg(rgd_pkg::REG_HEIGHT, h);
    write_reg(rgd_pkg::REG_RED, rgd_pkg::DIM_REG_W'(r));
    write_reg(rgd_pkg::REG_GREEN, rgd_pkg::DIM_REG_W'(g));
    write_reg(rgd_pkg::REG_BLUE, rgd_pkg::DIM_REG_W'(b));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Sender burst state: a request goes out only while burst_left > 0.
  int unsigned burst_left = 0;

  // Present one request and hold it until accepted; optional expected value
  // is checked against the predictor before queuing.
  task automatic send_request(rgd_pkg::pixel_req_t req, bit has_exp,
      rgd_pkg::pixel_rsp_t exp_val);
    rgd_pkg::pixel_rsp_t pred;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    pred = disc_pixel(req);
    if (has_exp && pred !== exp_val) begin
      $display("%0t table row disagrees with predictor: exp %h pred %h",
               $time, exp_val, pred);
      errors++;
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(has_exp ? exp_val : pred);
    requests_sent++;
    burst_left--;
    // Valid stays high; a gap or a drain drops it.
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stall pattern: alternating quiet stretches and busy stretches.
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[8]) out_stall <= 1'b0;
      else if (stall_phase[6]) out_stall <= ($urandom_range(0, 1) == 0);
      else out_stall <= ($urandom_range(0, 5) == 0);
    end
  end

  // Response checker: compare every accepted pixel with the oldest expectation.
  always @(posedge clk) begin
    rgd_pkg::pixel_rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected pixel %h", $time, out_data);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.alpha == rgd_pkg::ALPHA_ON) inside_seen++;
        if (out_data.alpha !== want.alpha) begin
          $display("%0t alpha mismatch: exp %0d got %0d", $time, want.alpha,
                   out_data.alpha);
          errors++;
        end
        if (out_data.red !== want.red) begin
          $display("%0t red mismatch: exp %0d got %0d", $time, want.red, out_data.red);
          errors++;
        end
        if (out_data.green !== want.green) begin
          $display("%0t green mismatch: exp %0d got %0d", $time, want.green,
                   out_data.green);
          errors++;
        end
        if (out_data.blue !== want.blue) begin
          $display("%0t blue mismatch: exp %0d got %0d", $time, want.blue, out_data.blue);
          errors++;
        end
      end
    end
  end

  // Directed table. Rows with chk set carry a result read straight off the
  // disc definition; the rest rely on the predictor.
  typedef struct {
    logic [rgd_pkg::DIM_REG_W-1:0] w, h;
    logic [rgd_pkg::COLOR_W-1:0]   pr, pg, pb;
    logic [rgd_pkg::COORD_W-1:0]   x, y;
    bit                            chk;
    rgd_pkg::pixel_rsp_t           res;
  } vector_row_t;

  localparam rgd_pkg::pixel_rsp_t BLANK = '0;
  vector_row_t vectors[] = '{
    // reset sprite 32x32: center, corner, one past edge, far extremes
    '{11'd32, 11'd32, 8'd255, 8'd255, 8'd255, 10'd16, 10'd16, 1, '{8'd255, 8'd0, 8'd0, 8'd0}},
    '{11'd32, 11'd32, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1, BLANK},
    '{11'd32, 11'd32, 8'd255, 8'd255, 8'd255, 10'd32, 10'd16, 1, BLANK},
    '{11'd32, 11'd32, 8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 1, BLANK},
    // on the rim: x=0,y=16 gives S=m*m, full peak
    '{11'd32, 11'd32, 8'd255, 8'd255, 8'd255, 10'd0, 10'd16, 1,
      '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{11'd32, 11'd32, 8'd255, 8'd255, 8'd255, 10'd5, 10'd20, 0, BLANK},
    // zero dimension: all outside
    '{11'd0, 11'd32, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1, BLANK},
    '{11'd32, 11'd0, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1, BLANK},
    // single pixel sprite: S=2, m=1, outside
    '{11'd1, 11'd1, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1, BLANK},
    // largest register values act as MAX_DIM
    '{11'd2047, 11'd2047, 8'd200, 8'd100, 8'd7, 10'd512, 10'd512, 1,
      '{8'd255, 8'd0, 8'd0, 8'd0}},
    '{11'd2047, 11'd2047, 8'd200, 8'd100, 8'd7, 10'd1023, 10'd512, 0, BLANK},
    '{11'd2047, 11'd2047, 8'd200, 8'd100, 8'd7, 10'd0, 10'd512, 1,
      '{8'd255, 8'd200, 8'd100, 8'd7}},
    '{11'd1024, 11'd1024, 8'd0, 8'd255, 8'd128, 10'd300, 10'd700, 0, BLANK},
    '{11'd1024, 11'd1024, 8'd0, 8'd255, 8'd128, 10'd1023, 10'd1023, 1, BLANK},
    // wide and tall sprites
    '{11'd1024, 11'd3, 8'd255, 8'd1, 8'd170, 10'd512, 10'd1, 0, BLANK},
    '{11'd5, 11'd1000, 8'd85, 8'd255, 8'd0, 10'd2, 10'd600, 0, BLANK},
    '{11'd5, 11'd1000, 8'd85, 8'd255, 8'd0, 10'd5, 10'd500, 1, BLANK},
    '{11'd1000, 11'd1023, 8'd255, 8'd254, 8'd253, 10'd999, 10'd1022, 0, BLANK},
    '{11'd1000, 11'd1023, 8'd255, 8'd254, 8'd253, 10'd600, 10'd300, 0, BLANK}
  };

  initial begin
    rgd_pkg::pixel_req_t req;
    logic [rgd_pkg::DIM_REG_W-1:0] w, h;
    int unsigned n;
    img_w = rgd_pkg::WIDTH_RST;  img_h = rgd_pkg::HEIGHT_RST;
    peak_r = rgd_pkg::PEAK_RST;  peak_g = rgd_pkg::PEAK_RST;  peak_b = rgd_pkg::PEAK_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].w != img_w || vectors[i].h != img_h || vectors[i].pr != peak_r ||
          vectors[i].pg != peak_g || vectors[i].pb != peak_b) begin
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        set_sprite(vectors[i].w, vectors[i].h, vectors[i].pr, vectors[i].pg, vectors[i].pb);
      end
      req.pixel_x = vectors[i].x;
      req.pixel_y = vectors[i].y;
      send_request(req, vectors[i].chk, vectors[i].res);
    end

    // Random phases: new sprite settings, then a stream of coordinates,
    // mostly inside the image and a share anywhere in the field range.
    for (int phase = 0; phase < 12; phase++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (phase % 4)
        0: begin
          w = rgd_pkg::DIM_REG_W'($urandom_range(1, 64));
          h = rgd_pkg::DIM_REG_W'($urandom_range(1, 64));
        end
        1: begin
          w = rgd_pkg::DIM_REG_W'($urandom_range(1, 1024));
          h = rgd_pkg::DIM_REG_W'($urandom_range(1, 1024));
        end
        2: begin
          w = rgd_pkg::DIM_REG_W'($urandom_range(0, 2047));
          h = rgd_pkg::DIM_REG_W'($urandom_range(0, 2047));
        end
        default: begin
          w = rgd_pkg::DIM_REG_W'($urandom_range(1, 16));
          h = rgd_pkg::DIM_REG_W'($urandom_range(1, 300));
        end
      endcase
      set_sprite(w, h, rgd_pkg::COLOR_W'($urandom_range(0, 255)),
                 rgd_pkg::COLOR_W'($urandom_range(0, 255)),
                 rgd_pkg::COLOR_W'($urandom_range(0, 255)));
      n = 80;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 4) != 0 && w != 0 && h != 0) begin
          req.pixel_x = rgd_pkg::COORD_W'($urandom_range(0, (w > 1024 ? 1024 : w) - 1));
          req.pixel_y = rgd_pkg::COORD_W'($urandom_range(0, (h > 1024 ? 1024 : h) - 1));
        end else begin
          req.pixel_x = rgd_pkg::COORD_W'($urandom_range(0, 1023));
          req.pixel_y = rgd_pkg::COORD_W'($urandom_range(0, 1023));
        end
        send_request(req, 0, BLANK);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d sprite settings; %0d pixels checked, %0d inside.",
             requests_sent, settings_used, pixels_seen, inside_seen);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("tb_radial_gradient_disc_pixel_top: done, clean");
    end else begin
      $display("tb_radial_gradient_disc_pixel_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #5ms;
    $display("Timeout with %0d pixels outstanding", expected_pixels.size());
    $display("tb_radial_gradient_disc_pixel_top: done, errors");
    $finish;
  end
endmodule
